// ===== hw/rtl/clrc_pkg.sv =====
package clrc_pkg;

  // Display geometry
  localparam int ROWS  = 2;
  localparam int COLS  = 16;
  localparam int CELLS = ROWS * COLS;

  localparam int CELL_W = $clog2(CELLS);
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W  = $clog2(COLS);

  typedef logic [CELL_W-1:0] cell_idx_t;
  typedef logic [CELL_W:0]   sweep_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [7:0]        byte_t;

  // Item commands
  localparam logic [2:0] CMD_TICK      = 3'd0;
  localparam logic [2:0] CMD_PUT_CHAR  = 3'd1;
  localparam logic [2:0] CMD_SET_CUR   = 3'd2;
  localparam logic [2:0] CMD_HOME      = 3'd3;
  localparam logic [2:0] CMD_CLR_ALL   = 3'd4;
  localparam logic [2:0] CMD_CLR_LINE  = 3'd5;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_BOOT_WAIT = 2'd0;
  localparam cfg_idx_t CFG_CMD_WAIT  = 2'd1;
  localparam cfg_idx_t CFG_DISP_EN   = 2'd2;

  localparam byte_t BOOT_WAIT_RST = 8'd50;
  localparam byte_t CMD_WAIT_RST  = 8'd4;

  // Init sequence steps
  localparam logic [2:0] INIT_BOOT   = 3'd0;
  localparam logic [2:0] INIT_WAKE   = 3'd1;
  localparam logic [2:0] INIT_SETTLE = 3'd2;
  localparam logic [2:0] INIT_FUNC   = 3'd3;
  localparam logic [2:0] INIT_CLEAR  = 3'd4;
  localparam logic [2:0] INIT_ENTRY  = 3'd5;
  localparam logic [2:0] INIT_DISP   = 3'd6;
  localparam logic [2:0] INIT_DONE   = 3'd7;

  // HD44780 codes
  localparam byte_t      SPACE_CHAR   = 8'h20;
  localparam byte_t      DDRAM_BASE   = 8'h80;
  localparam byte_t      ROW_ODD_OFS  = 8'h40;
  localparam logic [3:0] WAKE_NIB     = 4'h3;
  localparam logic [3:0] BUS4_NIB     = 4'h2;
  localparam byte_t      FUNC_SET     = 8'h28;
  localparam byte_t      DISP_OFF     = 8'h08;
  localparam byte_t      DISP_ON      = 8'h0C;
  localparam byte_t      CLEAR_DISP   = 8'h01;
  localparam byte_t      ENTRY_MODE   = 8'h06;

  // Nibble queue
  localparam int Q_DEPTH = 7;
  typedef logic [2:0] qcnt_t;

  typedef struct packed {
    logic       rs;
    logic [3:0] nib;
  } nib_t;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] char_code;
    logic [1:0] row_sel;
    logic [4:0] col_sel;
  } item_t;

  typedef struct packed {
    logic       reg_select;
    logic [3:0] nibble;
    logic       last;
  } res_t;

  typedef struct packed {
    logic capture;
    logic edit;
    logic init_tick;
    logic copy_start;
    logic copy_step;
    logic copy_finish;
    logic ref_read;
    logic ref_load;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    logic is_tick;
    logic init_done;
    logic refreshing;
    logic sweep_done;
    logic q_empty;
    logic q_one;
  } stat_t;

endpackage

// ===== hw/rtl/clrc_ctrl.sv =====
module clrc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  clrc_pkg::stat_t stat_i,
  output clrc_pkg::ctrl_t ctrl_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_COPY   = 5'b00100,
    S_REFRD  = 5'b01000,
    S_EMIT   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ctrl_o.capture = 1'b1;
          state_d        = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!stat_i.is_tick) begin
          ctrl_o.edit = 1'b1;
          state_d     = S_IDLE;
        end else if (!stat_i.init_done) begin
          ctrl_o.init_tick = 1'b1;
          state_d          = S_EMIT;
        end else if (stat_i.refreshing) begin
          ctrl_o.ref_read = 1'b1;
          state_d         = S_REFRD;
        end else begin
          ctrl_o.copy_start = 1'b1;
          state_d           = S_COPY;
        end
      end
      S_COPY: begin
        if (stat_i.sweep_done) begin
          ctrl_o.copy_finish = 1'b1;
          state_d            = S_EMIT;
        end else begin
          ctrl_o.copy_step = 1'b1;
        end
      end
      S_REFRD: begin
        ctrl_o.ref_load = 1'b1;
        state_d         = S_EMIT;
      end
      S_EMIT: begin
        if (stat_i.q_empty) begin
          state_d = S_IDLE;
        end else begin
          ctrl_o.emit = 1'b1;
          if (stat_i.q_one) state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ===== hw/rtl/clrc_datapath.sv =====
module clrc_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  clrc_pkg::ctrl_t     ctrl_i,
  output clrc_pkg::stat_t     stat_o,
  input  clrc_pkg::item_t     item_i,
  input  logic                cfg_we_i,
  input  clrc_pkg::cfg_idx_t  cfg_index_i,
  input  logic [7:0]          cfg_data_i,
  output logic                res_strobe_o,
  output clrc_pkg::res_t      res_o
);

  localparam clrc_pkg::cell_idx_t COLS_IDX  = clrc_pkg::cell_idx_t'(clrc_pkg::COLS);
  localparam clrc_pkg::cell_idx_t CELL_LAST = clrc_pkg::cell_idx_t'(clrc_pkg::CELLS - 1);
  localparam clrc_pkg::sweep_t    SWEEP_END = clrc_pkg::sweep_t'(clrc_pkg::CELLS);
  localparam clrc_pkg::row_t      ROW_LAST  = clrc_pkg::row_t'(clrc_pkg::ROWS - 1);
  localparam clrc_pkg::col_t      COL_LAST  = clrc_pkg::col_t'(clrc_pkg::COLS - 1);
  localparam clrc_pkg::byte_t     COLS_BYTE = clrc_pkg::byte_t'(clrc_pkg::COLS);

  function automatic clrc_pkg::nib_t mk_nib(input logic rs, input logic [3:0] v);
    clrc_pkg::nib_t n;
    n.rs  = rs;
    n.nib = v;
    return n;
  endfunction

  // Architectural state
  clrc_pkg::item_t     item_q;
  clrc_pkg::byte_t     cmd_wait_q;
  logic                disp_en_q;
  logic [2:0]          init_step_q, init_step_d;
  clrc_pkg::byte_t     wait_q, wait_d;
  logic                applied_q, applied_d;
  logic                refreshing_q, refreshing_d;
  clrc_pkg::row_t      ref_row_q, ref_row_d;
  clrc_pkg::col_t      ref_col_q, ref_col_d;
  clrc_pkg::cell_idx_t wr_cur_q, wr_cur_d;
  logic [clrc_pkg::CELLS-1:0] pend_vld_q, shown_vld_q;

  // Copy sweep
  clrc_pkg::sweep_t    sweep_q;
  logic                pipe_q;
  clrc_pkg::cell_idx_t pipe_addr_q;
  logic                diff_q;

  // Buffers
  clrc_pkg::byte_t     pend_mem  [clrc_pkg::CELLS];
  clrc_pkg::byte_t     shown_mem [clrc_pkg::CELLS];
  clrc_pkg::byte_t     pend_rd_q, shown_rd_q;
  logic                pend_rd_vld_q, shown_rd_vld_q;
  clrc_pkg::byte_t     pend_val, shown_val;

  // Nibble queue
  clrc_pkg::nib_t      queue_q [clrc_pkg::Q_DEPTH];
  clrc_pkg::nib_t      q_ld    [clrc_pkg::Q_DEPTH];
  clrc_pkg::qcnt_t     qcnt_q, q_ld_cnt;
  logic                q_load;

  logic                res_strobe_q;
  clrc_pkg::res_t      res_q;

  // Edit decode
  logic                cmd_put, cmd_clr_all, cmd_clr_line, row_ok;
  logic [clrc_pkg::CELLS-1:0] line_hit;
  clrc_pkg::row_t      row_c;
  clrc_pkg::col_t      col_c;

  // Memory ports
  logic                pend_we, pend_re, shown_we, shown_re;
  clrc_pkg::cell_idx_t sweep_idx, ref_idx, shown_ra;

  // Tick helpers
  logic                tail;
  clrc_pkg::byte_t     disp_byte, ref_addr, row_hi;

  assign pend_val  = pend_rd_vld_q  ? pend_rd_q  : clrc_pkg::SPACE_CHAR;
  assign shown_val = shown_rd_vld_q ? shown_rd_q : clrc_pkg::SPACE_CHAR;

  assign cmd_put      = ctrl_i.edit && (item_q.command == clrc_pkg::CMD_PUT_CHAR);
  assign cmd_clr_all  = ctrl_i.edit && (item_q.command == clrc_pkg::CMD_CLR_ALL);
  assign cmd_clr_line = ctrl_i.edit && (item_q.command == clrc_pkg::CMD_CLR_LINE);
  assign row_ok       = (int'(item_q.row_sel) < clrc_pkg::ROWS);

  always_comb begin
    int row_base;
    row_base = int'(item_q.row_sel) * clrc_pkg::COLS;
    for (int i = 0; i < clrc_pkg::CELLS; i++) begin
      line_hit[i] = row_ok && (i >= row_base) && (i < row_base + clrc_pkg::COLS);
    end
  end

  // Clamp set-cursor coordinates to the last row and column
  assign row_c = (int'(item_q.row_sel) >= clrc_pkg::ROWS) ? ROW_LAST
                                                          : clrc_pkg::row_t'(item_q.row_sel);
  assign col_c = (int'(item_q.col_sel) >= clrc_pkg::COLS) ? COL_LAST
                                                          : clrc_pkg::col_t'(item_q.col_sel);

  always_comb begin
    wr_cur_d = wr_cur_q;
    if (ctrl_i.edit) begin
      case (item_q.command)
        clrc_pkg::CMD_PUT_CHAR: begin
          wr_cur_d = (wr_cur_q == CELL_LAST) ? '0
                                             : clrc_pkg::cell_idx_t'(wr_cur_q + 1'b1);
        end
        clrc_pkg::CMD_SET_CUR: begin
          wr_cur_d = clrc_pkg::cell_idx_t'(clrc_pkg::cell_idx_t'(row_c) * COLS_IDX
                                           + clrc_pkg::cell_idx_t'(col_c));
        end
        clrc_pkg::CMD_HOME: begin
          wr_cur_d = '0;
        end
        default: begin
          wr_cur_d = wr_cur_q;
        end
      endcase
    end
  end

  // Memory port control
  assign sweep_idx = sweep_q[clrc_pkg::CELL_W-1:0];
  assign ref_idx   = clrc_pkg::cell_idx_t'(clrc_pkg::cell_idx_t'(ref_row_q) * COLS_IDX
                                           + clrc_pkg::cell_idx_t'(ref_col_q));
  assign pend_we   = cmd_put;
  assign pend_re   = ctrl_i.copy_step && (sweep_q != SWEEP_END);
  assign shown_we  = ctrl_i.copy_step && pipe_q;
  assign shown_re  = pend_re || ctrl_i.ref_read;
  assign shown_ra  = ctrl_i.ref_read ? ref_idx : sweep_idx;

  always_ff @(posedge clk_i) begin
    if (pend_we) pend_mem[wr_cur_q] <= item_q.char_code;
    if (pend_re) begin
      pend_rd_q     <= pend_mem[sweep_idx];
      pend_rd_vld_q <= pend_vld_q[sweep_idx];
    end
    if (shown_we) shown_mem[pipe_addr_q] <= pend_val;
    if (shown_re) begin
      shown_rd_q     <= shown_mem[shown_ra];
      shown_rd_vld_q <= shown_vld_q[shown_ra];
    end
  end

  // DDRAM address of the refresh cell
  assign row_hi   = clrc_pkg::byte_t'(ref_row_q >> 1);
  assign ref_addr = clrc_pkg::byte_t'(clrc_pkg::DDRAM_BASE
                    + (ref_row_q[0] ? clrc_pkg::ROW_ODD_OFS : 8'h00)
                    + clrc_pkg::byte_t'(row_hi * COLS_BYTE)
                    + clrc_pkg::byte_t'(ref_col_q));

  assign tail      = (applied_q != disp_en_q);
  assign disp_byte = disp_en_q ? clrc_pkg::DISP_ON : clrc_pkg::DISP_OFF;

  always_comb begin
    init_step_d  = init_step_q;
    wait_d       = wait_q;
    applied_d    = applied_q;
    refreshing_d = refreshing_q;
    ref_row_d    = ref_row_q;
    ref_col_d    = ref_col_q;
    q_load       = ctrl_i.init_tick || ctrl_i.copy_finish || ctrl_i.ref_load;
    q_ld_cnt     = '0;
    for (int i = 0; i < clrc_pkg::Q_DEPTH; i++) q_ld[i] = '0;

    if (ctrl_i.init_tick) begin
      case (init_step_q)
        clrc_pkg::INIT_BOOT: begin
          wait_d = wait_q - 8'd1;
          if (wait_d == 8'd0) init_step_d = clrc_pkg::INIT_WAKE;
        end
        clrc_pkg::INIT_WAKE: begin
          q_ld[0]     = mk_nib(1'b0, clrc_pkg::WAKE_NIB);
          q_ld_cnt    = 3'd1;
          wait_d      = cmd_wait_q;
          init_step_d = clrc_pkg::INIT_SETTLE;
        end
        clrc_pkg::INIT_SETTLE: begin
          wait_d = wait_q - 8'd1;
          if (wait_d == 8'd0) init_step_d = clrc_pkg::INIT_FUNC;
        end
        clrc_pkg::INIT_FUNC: begin
          q_ld[0]     = mk_nib(1'b0, clrc_pkg::WAKE_NIB);
          q_ld[1]     = mk_nib(1'b0, clrc_pkg::WAKE_NIB);
          q_ld[2]     = mk_nib(1'b0, clrc_pkg::BUS4_NIB);
          q_ld[3]     = mk_nib(1'b0, clrc_pkg::FUNC_SET[7:4]);
          q_ld[4]     = mk_nib(1'b0, clrc_pkg::FUNC_SET[3:0]);
          q_ld[5]     = mk_nib(1'b0, clrc_pkg::DISP_OFF[7:4]);
          q_ld[6]     = mk_nib(1'b0, clrc_pkg::DISP_OFF[3:0]);
          q_ld_cnt    = 3'd7;
          init_step_d = clrc_pkg::INIT_CLEAR;
        end
        clrc_pkg::INIT_CLEAR: begin
          q_ld[0]     = mk_nib(1'b0, clrc_pkg::CLEAR_DISP[7:4]);
          q_ld[1]     = mk_nib(1'b0, clrc_pkg::CLEAR_DISP[3:0]);
          q_ld_cnt    = 3'd2;
          init_step_d = clrc_pkg::INIT_ENTRY;
        end
        clrc_pkg::INIT_ENTRY: begin
          q_ld[0]     = mk_nib(1'b0, clrc_pkg::ENTRY_MODE[7:4]);
          q_ld[1]     = mk_nib(1'b0, clrc_pkg::ENTRY_MODE[3:0]);
          q_ld_cnt    = 3'd2;
          init_step_d = clrc_pkg::INIT_DISP;
        end
        clrc_pkg::INIT_DISP: begin
          q_ld[0]     = mk_nib(1'b0, disp_byte[7:4]);
          q_ld[1]     = mk_nib(1'b0, disp_byte[3:0]);
          q_ld_cnt    = 3'd2;
          applied_d   = disp_en_q;
          init_step_d = clrc_pkg::INIT_DONE;
        end
        default: begin
          init_step_d = init_step_q;
        end
      endcase
    end

    if (ctrl_i.copy_finish) begin
      if (diff_q) begin
        refreshing_d = 1'b1;
        ref_row_d    = '0;
        ref_col_d    = '0;
      end
      if (tail) begin
        q_ld[0]   = mk_nib(1'b0, disp_byte[7:4]);
        q_ld[1]   = mk_nib(1'b0, disp_byte[3:0]);
        q_ld_cnt  = 3'd2;
        applied_d = disp_en_q;
      end
    end

    if (ctrl_i.ref_load) begin
      q_ld[0]  = mk_nib(1'b0, ref_addr[7:4]);
      q_ld[1]  = mk_nib(1'b0, ref_addr[3:0]);
      q_ld[2]  = mk_nib(1'b1, shown_val[7:4]);
      q_ld[3]  = mk_nib(1'b1, shown_val[3:0]);
      q_ld_cnt = 3'd4;
      if (tail) begin
        q_ld[4]   = mk_nib(1'b0, disp_byte[7:4]);
        q_ld[5]   = mk_nib(1'b0, disp_byte[3:0]);
        q_ld_cnt  = 3'd6;
        applied_d = disp_en_q;
      end
      if (ref_col_q == COL_LAST) begin
        ref_col_d = '0;
        if (ref_row_q == ROW_LAST) begin
          ref_row_d    = '0;
          refreshing_d = 1'b0;
        end else begin
          ref_row_d = clrc_pkg::row_t'(ref_row_q + 1'b1);
        end
      end else begin
        ref_col_d = clrc_pkg::col_t'(ref_col_q + 1'b1);
      end
    end

    // Boot wait written during boot reloads the counter; that is its only effect
    if (cfg_we_i && (cfg_index_i == clrc_pkg::CFG_BOOT_WAIT)
        && (init_step_q == clrc_pkg::INIT_BOOT)) begin
      wait_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_wait_q   <= clrc_pkg::CMD_WAIT_RST;
      disp_en_q    <= 1'b1;
      init_step_q  <= clrc_pkg::INIT_BOOT;
      wait_q       <= clrc_pkg::BOOT_WAIT_RST;
      applied_q    <= 1'b0;
      refreshing_q <= 1'b0;
      ref_row_q    <= '0;
      ref_col_q    <= '0;
      wr_cur_q     <= '0;
      pend_vld_q   <= '0;
      shown_vld_q  <= '0;
      sweep_q      <= '0;
      pipe_q       <= 1'b0;
      diff_q       <= 1'b0;
      qcnt_q       <= '0;
      res_strobe_q <= 1'b0;
    end else begin
      init_step_q  <= init_step_d;
      wait_q       <= wait_d;
      applied_q    <= applied_d;
      refreshing_q <= refreshing_d;
      ref_row_q    <= ref_row_d;
      ref_col_q    <= ref_col_d;
      wr_cur_q     <= wr_cur_d;
      res_strobe_q <= ctrl_i.emit;

      if (cfg_we_i) begin
        case (cfg_index_i)
          clrc_pkg::CFG_CMD_WAIT:  cmd_wait_q  <= cfg_data_i;
          clrc_pkg::CFG_DISP_EN:   disp_en_q   <= cfg_data_i[0];
          default: begin
          end
        endcase
      end

      if (cmd_put) pend_vld_q[wr_cur_q] <= 1'b1;
      if (cmd_clr_all) pend_vld_q <= '0;
      if (cmd_clr_line) pend_vld_q <= pend_vld_q & ~line_hit;
      if (shown_we) shown_vld_q[pipe_addr_q] <= 1'b1;

      if (ctrl_i.copy_start) begin
        sweep_q <= '0;
        pipe_q  <= 1'b0;
        diff_q  <= 1'b0;
      end else if (ctrl_i.copy_step) begin
        if (sweep_q != SWEEP_END) sweep_q <= clrc_pkg::sweep_t'(sweep_q + 1'b1);
        pipe_q <= (sweep_q != SWEEP_END);
        if (pipe_q && (pend_val != shown_val)) diff_q <= 1'b1;
      end

      if (q_load) begin
        qcnt_q <= q_ld_cnt;
      end else if (ctrl_i.emit) begin
        qcnt_q <= clrc_pkg::qcnt_t'(qcnt_q - 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) item_q <= item_i;
    if (ctrl_i.copy_step) pipe_addr_q <= sweep_idx;
    if (q_load) begin
      for (int i = 0; i < clrc_pkg::Q_DEPTH; i++) queue_q[i] <= q_ld[i];
    end else if (ctrl_i.emit) begin
      for (int i = 0; i < clrc_pkg::Q_DEPTH - 1; i++) queue_q[i] <= queue_q[i+1];
      queue_q[clrc_pkg::Q_DEPTH-1] <= '0;
    end
    if (ctrl_i.emit) begin
      res_q.reg_select <= queue_q[0].rs;
      res_q.nibble     <= queue_q[0].nib;
      res_q.last       <= (qcnt_q == 3'd1);
    end
  end

  assign stat_o.is_tick    = (item_q.command == clrc_pkg::CMD_TICK);
  assign stat_o.init_done  = (init_step_q == clrc_pkg::INIT_DONE);
  assign stat_o.refreshing = refreshing_q;
  assign stat_o.sweep_done = (sweep_q == SWEEP_END) && !pipe_q;
  assign stat_o.q_empty    = (qcnt_q == 3'd0);
  assign stat_o.q_one      = (qcnt_q == 3'd1);

  assign res_strobe_o = res_strobe_q;
  assign res_o        = res_q;

endmodule

// ===== hw/rtl/char_lcd_refresh_controller.sv =====
// Edit items (put char, cursor, clear): busy only while decoded, a new edit once idle, no results.
// Init and refresh ticks: the nibble queue is loaded at decode (a refresh tick first
// reads the shown buffer), then strobed out one nibble per cycle (up to 7).
// Idle ticks sweep both 32-entry buffers one entry per cycle; a display-enable change then
// adds 2 strobes. The receiver cannot stall.
// Reset clears control state and all buffer valid bits (buffers read as spaces).
module char_lcd_refresh_controller (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Item command channel
  input  logic               start,
  output logic               busy,
  input  clrc_pkg::item_t    item_i,
  // Configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  clrc_pkg::cfg_idx_t cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  // Result nibbles, one beat per strobe
  output logic               res_strobe_o,
  output clrc_pkg::res_t     res_o
);

  clrc_pkg::ctrl_t ctrl;
  clrc_pkg::stat_t stat;
  logic            cfg_we;

  // Take configuration beats only while idle; writes never land mid-item.
  assign cfg_ready_o = !busy;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // Sequencer: decode the item, run the copy sweep or refresh read,
  // then drain the nibble queue.
  clrc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .stat_i  (stat),
    .ctrl_o  (ctrl)
  );

  // Buffers, cursors, init state and the output nibble queue.
  clrc_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .item_i       (item_i),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

`ifndef SYNTHESIS
  // A non-final nibble always has more queued behind it, so the block stays busy.
  a_mid_beat_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && !res_o.last) |-> busy)
    else $error("non-final nibble strobed while idle");

  // The final nibble of a tick is never followed directly by another strobe.
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && res_o.last) |=> !res_strobe_o)
    else $error("strobe directly after final nibble");

  // An accepted item always occupies the block for the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import clrc_pkg::*;

  // Command codes the block does not define; it must accept and drop them.
  localparam logic [2:0] CMD_RSVD_A = 3'd6;
  localparam logic [2:0] CMD_RSVD_B = 3'd7;

  // An idle tick sweeps both buffers and may add two strobes.
  localparam int SETTLE_CYCLES = 60;
  localparam int DRAIN_LIMIT   = 2000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  item_t    cmd_item = '0;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  cfg_idx_t cfg_index = CFG_BOOT_WAIT;
  byte_t    cfg_data = '0;
  logic     nib_strobe;
  res_t     nib_out;

  char_lcd_refresh_controller uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start       (start),
    .busy        (busy),
    .item_i      (cmd_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .res_strobe_o(nib_strobe),
    .res_o       (nib_out)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Display model: frame buffers, cursors, init sequencer and register copies
  // ---------------------------------------------------------------------------
  byte_t      pend_buf [CELLS];
  byte_t      shown_buf[CELLS];
  int         wr_cell;
  int         sweep_cell;
  bit         sweeping;
  logic [2:0] init_st;
  byte_t      wait_cnt;
  bit         disp_on;
  byte_t      boot_wait;
  byte_t      cmd_wait;
  bit         disp_req;

  res_t tick_nibs[$];   // nibbles produced by the tick being modeled
  res_t nib_expect[$];  // nibbles the LCD bus still owes us, oldest first
  res_t want_nib;
  int   errors;
  bit   no_gaps;        // set for the stretch where the sender never idles

  function automatic void reset_model();
    foreach (pend_buf[i]) begin
      pend_buf[i]  = SPACE_CHAR;
      shown_buf[i] = SPACE_CHAR;
    end
    wr_cell    = 0;
    sweep_cell = 0;
    sweeping   = 1'b0;
    init_st    = INIT_BOOT;
    boot_wait  = BOOT_WAIT_RST;
    cmd_wait   = CMD_WAIT_RST;
    disp_req   = 1'b1;
    wait_cnt   = BOOT_WAIT_RST;
    disp_on    = 1'b0;
  endfunction

  function automatic void add_nib(logic rs, logic [3:0] v);
    res_t r;
    r.reg_select = rs;
    r.nibble     = v;
    r.last       = 1'b0;
    tick_nibs.push_back(r);
  endfunction

  // High nibble goes out first on the 4-bit bus.
  function automatic void add_byte(logic rs, byte_t b);
    add_nib(rs, b[7:4]);
    add_nib(rs, b[3:0]);
  endfunction

  function automatic void apply_display();
    disp_on = disp_req;
    add_byte(1'b0, disp_on ? DISP_ON : DISP_OFF);
  endfunction

  // Power-on init: boot wait, wake nibble, settle wait, then the command burst.
  function automatic void init_tick();
    case (init_st)
      INIT_BOOT: begin
        wait_cnt = wait_cnt - 8'd1;
        if (wait_cnt == 8'd0) init_st = INIT_WAKE;
      end
      INIT_WAKE: begin
        add_nib(1'b0, WAKE_NIB);
        wait_cnt = cmd_wait;
        init_st  = INIT_SETTLE;
      end
      INIT_SETTLE: begin
        wait_cnt = wait_cnt - 8'd1;
        if (wait_cnt == 8'd0) init_st = INIT_FUNC;
      end
      INIT_FUNC: begin
        add_nib(1'b0, WAKE_NIB);
        add_nib(1'b0, WAKE_NIB);
        add_nib(1'b0, BUS4_NIB);
        add_byte(1'b0, FUNC_SET);
        add_byte(1'b0, DISP_OFF);
        init_st = INIT_CLEAR;
      end
      INIT_CLEAR: begin
        add_byte(1'b0, CLEAR_DISP);
        init_st = INIT_ENTRY;
      end
      INIT_ENTRY: begin
        add_byte(1'b0, ENTRY_MODE);
        init_st = INIT_DISP;
      end
      INIT_DISP: begin
        apply_display();
        init_st = INIT_DONE;
      end
      default: ;
    endcase
  endfunction

  // After init: an idle tick snapshots pending into shown when they differ;
  // a refreshing tick sends one cell as address command plus data byte.
  function automatic void refresh_tick();
    bit    differs;
    int    row;
    int    col;
    byte_t addr;
    if (!sweeping) begin
      differs = 1'b0;
      foreach (pend_buf[i])
        if (pend_buf[i] != shown_buf[i]) differs = 1'b1;
      if (differs) begin
        shown_buf  = pend_buf;
        sweeping   = 1'b1;
        sweep_cell = 0;
      end
    end else begin
      if (sweep_cell >= CELLS) sweep_cell = 0;
      row  = sweep_cell / COLS;
      col  = sweep_cell % COLS;
      addr = byte_t'(int'(DDRAM_BASE) + int'(ROW_ODD_OFS) * (row % 2)
                     + COLS * (row / 2) + col);
      add_byte(1'b0, addr);
      add_byte(1'b1, shown_buf[sweep_cell]);
      sweep_cell++;
      if (sweep_cell >= CELLS) begin
        sweeping   = 1'b0;
        sweep_cell = 0;
      end
    end
    if (disp_on != disp_req) apply_display();
  endfunction

  function automatic void predict_item(item_t it);
    int row;
    int col;
    tick_nibs.delete();
    case (it.command)
      CMD_TICK: begin
        if (init_st != INIT_DONE) init_tick();
        else refresh_tick();
      end
      CMD_PUT_CHAR: begin
        pend_buf[wr_cell] = it.char_code;
        wr_cell = (wr_cell + 1) % CELLS;
      end
      CMD_SET_CUR: begin
        col = (int'(it.col_sel) >= COLS) ? COLS - 1 : int'(it.col_sel);
        row = (int'(it.row_sel) >= ROWS) ? ROWS - 1 : int'(it.row_sel);
        wr_cell = row * COLS + col;
      end
      CMD_HOME: wr_cell = 0;
      CMD_CLR_ALL: begin
        foreach (pend_buf[i]) pend_buf[i] = SPACE_CHAR;
      end
      CMD_CLR_LINE: begin
        if (int'(it.row_sel) < ROWS)
          for (int i = 0; i < COLS; i++) pend_buf[int'(it.row_sel) * COLS + i] = SPACE_CHAR;
      end
      default: ;
    endcase
    if (tick_nibs.size() > 0) tick_nibs[tick_nibs.size() - 1].last = 1'b1;
    foreach (tick_nibs[i]) nib_expect.push_back(tick_nibs[i]);
  endfunction

  function automatic void set_register(cfg_idx_t idx, byte_t d);
    case (idx)
      CFG_BOOT_WAIT: begin
        boot_wait = d;
        // still in the boot wait: the new value restarts the count
        if (init_st == INIT_BOOT) wait_cnt = d;
      end
      CFG_CMD_WAIT: cmd_wait = d;
      CFG_DISP_EN:  disp_req = d[0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers; every task returns right after a rising edge
  // ---------------------------------------------------------------------------
  function automatic item_t make_item(logic [2:0] cmd, byte_t ch, logic [1:0] row,
                                      logic [4:0] col);
    item_t it;
    it.command   = cmd;
    it.char_code = ch;
    it.row_sel   = row;
    it.col_sel   = col;
    return it;
  endfunction

  function automatic item_t rand_item(logic [2:0] cmd);
    return make_item(cmd, byte_t'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                     5'($urandom_range(0, 31)));
  endfunction

  // Mostly buffer edits, with a tail of anything the command field can hold.
  function automatic logic [2:0] pick_edit();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return CMD_PUT_CHAR;
    if (p < 70) return CMD_SET_CUR;
    if (p < 77) return CMD_HOME;
    if (p < 82) return CMD_CLR_ALL;
    if (p < 91) return CMD_CLR_LINE;
    if (p < 94) return CMD_RSVD_A;
    if (p < 96) return CMD_RSVD_B;
    return 3'($urandom_range(0, 7));
  endfunction

  // Idle the sender now and then: mostly short gaps, a few long ones so that
  // the next start lands at varying points of a running sweep.
  task automatic sender_pause();
    int n;
    if (!no_gaps && $urandom_range(0, 99) < 14) begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 45) : $urandom_range(1, 3);
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Present one item and hold it until the block takes the beat. Start stays
  // high when no gap follows, so the next item goes out back to back.
  task automatic send_item(item_t it);
    if (cfg_valid) cfg_valid <= 1'b0;
    start    <= 1'b1;
    cmd_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_item(it);
    sender_pause();
  endtask

  task automatic run_ticks(int n);
    repeat (n) send_item(rand_item(CMD_TICK));
  endtask

  // Drop start, wait for every owed nibble, then let a possible idle sweep end.
  task automatic wait_idle();
    int waited;
    waited = 0;
    start <= 1'b0;
    if (cfg_valid) cfg_valid <= 1'b0;
    while (nib_expect.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (nib_expect.size() != 0) begin
      $error("%0d expected nibbles never arrived", nib_expect.size());
      errors++;
      nib_expect.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Valid is left high so back-to-back writes need no extra edge; the next
  // send or drain drops it in the step of the last handshake.
  task automatic write_register(cfg_idx_t idx, byte_t d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    set_register(idx, d);
  endtask

  // ---------------------------------------------------------------------------
  // Result checking: each strobed nibble against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && nib_strobe) begin
      if (nib_expect.size() == 0) begin
        $error("unexpected nibble: reg_select=%0d nibble=%h last=%0d",
               nib_out.reg_select, nib_out.nibble, nib_out.last);
        errors++;
      end else begin
        want_nib = nib_expect.pop_front();
        if (nib_out.reg_select !== want_nib.reg_select) begin
          $error("reg_select: expected %0d, got %0d", want_nib.reg_select,
                 nib_out.reg_select);
          errors++;
        end
        if (nib_out.nibble !== want_nib.nibble) begin
          $error("nibble: expected %h, got %h", want_nib.nibble, nib_out.nibble);
          errors++;
        end
        if (nib_out.last !== want_nib.last) begin
          $error("last: expected %0d, got %0d", want_nib.last, nib_out.last);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Boot wait: rewrite the register while still counting, including zero,
  // which wraps the count; edits meanwhile must only touch pending.
  task automatic test_boot_wait();
    run_ticks(3);
    send_item(make_item(CMD_PUT_CHAR, 8'h48, 2'd0, 5'd0));
    send_item(make_item(CMD_SET_CUR, 8'h00, 2'd1, 5'd4));
    send_item(make_item(CMD_PUT_CHAR, 8'h69, 2'd0, 5'd0));
    wait_idle();
    write_register(CFG_BOOT_WAIT, 8'd255);
    run_ticks(4);
    wait_idle();
    write_register(CFG_BOOT_WAIT, 8'd0);
    run_ticks(3);
    wait_idle();
    write_register(CFG_BOOT_WAIT, 8'd1);
    run_ticks(1);
    wait_idle();
  endtask

  // Rest of init with a short settle wait and the display requested off,
  // so the final init step sends display-off.
  task automatic test_init_sequence();
    int n;
    n = 0;
    write_register(CFG_CMD_WAIT, 8'd3);
    write_register(CFG_DISP_EN, 8'd0);
    while (init_st != INIT_DONE) begin
      if (n % 20 == 7) send_item(rand_item(CMD_PUT_CHAR));
      else send_item(rand_item(CMD_TICK));
      n++;
    end
    run_ticks(2);
    wait_idle();
    // no effect once init is over, but the register must take it
    write_register(CFG_CMD_WAIT, 8'd255);
    write_register(CFG_BOOT_WAIT, 8'd200);
    run_ticks(1);
    wait_idle();
  endtask

  // Cursor clamping and wrap, byte extremes, bad clear rows, unknown codes,
  // then full refresh sweeps to read the frame back.
  task automatic test_buffer_edits();
    send_item(make_item(CMD_HOME, 8'h00, 2'd0, 5'd0));
    send_item(make_item(CMD_PUT_CHAR, 8'h00, 2'd0, 5'd0));
    send_item(make_item(CMD_PUT_CHAR, 8'hFF, 2'd3, 5'd31));
    send_item(make_item(CMD_SET_CUR, 8'hFF, 2'd3, 5'd31));
    send_item(make_item(CMD_PUT_CHAR, 8'h41, 2'd0, 5'd0));
    send_item(make_item(CMD_PUT_CHAR, 8'h7E, 2'd0, 5'd0));
    send_item(make_item(CMD_SET_CUR, 8'h00, 2'd1, 5'd0));
    send_item(make_item(CMD_PUT_CHAR, 8'h55, 2'd0, 5'd0));
    send_item(make_item(CMD_SET_CUR, 8'h00, 2'd0, 5'd15));
    send_item(make_item(CMD_PUT_CHAR, 8'hAA, 2'd3, 5'd31));
    send_item(make_item(CMD_SET_CUR, 8'h00, 2'd0, 5'd16));
    send_item(make_item(CMD_PUT_CHAR, 8'h5A, 2'd0, 5'd0));
    send_item(make_item(CMD_CLR_LINE, 8'h00, 2'd2, 5'd0));
    send_item(make_item(CMD_CLR_LINE, 8'hFF, 2'd3, 5'd31));
    send_item(make_item(CMD_RSVD_A, 8'hFF, 2'd3, 5'd31));
    send_item(make_item(CMD_RSVD_B, 8'h00, 2'd0, 5'd0));
    run_ticks(CELLS + 2);
    send_item(make_item(CMD_CLR_LINE, 8'h00, 2'd1, 5'd0));
    run_ticks(CELLS + 2);
    send_item(make_item(CMD_CLR_ALL, 8'hFF, 2'd3, 5'd31));
    run_ticks(CELLS + 2);
    wait_idle();
  endtask

  // Display-enable changes ride at the end of a tick: alone on an idle tick,
  // behind a refreshed cell otherwise (six nibbles in one tick).
  task automatic test_display_enable();
    write_register(CFG_DISP_EN, 8'd1);
    send_item(make_item(CMD_PUT_CHAR, 8'h31, 2'd0, 5'd0));
    send_item(make_item(CMD_PUT_CHAR, 8'h32, 2'd0, 5'd0));
    run_ticks(2);
    wait_idle();
    write_register(CFG_DISP_EN, 8'd0);
    run_ticks(1);
    run_ticks(CELLS + 2);
    wait_idle();
    write_register(CFG_DISP_EN, 8'd1);
    run_ticks(2);
    wait_idle();
  endtask

  // Rounds of edit bursts followed by tick runs, some long enough to finish a
  // sweep; registers change between rounds, one round runs without gaps.
  task automatic test_random_traffic();
    int sent;
    int burst;
    for (int rnd = 0; rnd < 3; rnd++) begin
      no_gaps = (rnd == 1);
      sent = 0;
      while (sent < 50) begin
        burst = $urandom_range(1, 8);
        repeat (burst) begin
          send_item(rand_item(pick_edit()));
          sent++;
        end
        burst = ($urandom_range(0, 2) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 12);
        repeat (burst) begin
          send_item(rand_item(CMD_TICK));
          sent++;
        end
      end
      wait_idle();
      no_gaps = 1'b0;
      write_register(CFG_DISP_EN, byte_t'($urandom_range(0, 1)));
      if (rnd % 2 == 0) write_register(CFG_BOOT_WAIT, byte_t'($urandom_range(0, 255)));
      else write_register(CFG_CMD_WAIT, byte_t'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    errors  = 0;
    no_gaps = 1'b0;
    reset_model();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_boot_wait();
    test_init_sequence();
    test_buffer_edits();
    test_display_enable();
    test_random_traffic();
    wait_idle();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under a tenth of this.
  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

endmodule
